>>> design/bptc_pkg.sv
// Shared types, widths and constants for the barometer compensation block.
package bptc_pkg;

    // Field and datapath widths
    localparam int RAW_W  = 24;
    localparam int CAL_W  = 16;
    localparam int DT_W   = 25;
    localparam int TEMP_W = 19;
    localparam int PRES_W = 32;
    localparam int ACC_W  = 40;
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;
    localparam int PSUM_W = 64;
    localparam int IDX_W  = 3;

    // Temperature thresholds in 0.01 degC
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -19'sd1500;

    // Saturation limits of the pressure result
    localparam logic signed [PSUM_W-1:0] PRES_MAX = 64'sd2147483647;
    localparam logic signed [PSUM_W-1:0] PRES_MIN = -64'sd2147483648;

    // Calibration register indexes
    localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
    localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
    localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
    localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

    // Calibration words C1..C6
    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    // Sequencer steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_DT,
        S_MTEMP,
        S_MOFF,
        S_MSENS,
        S_MT2,
        S_MD,
        S_ME,
        S_CORR1,
        S_CORR2,
        S_MPL,
        S_MPH,
        S_PSUM,
        S_PSUB,
        S_DONE
    } t_state;

endpackage

>>> design/baro_pressure_temp_compensation.sv
// Top level: calibration registers and the compensation sequencer.
//
// Barometer temperature and pressure compensation. Each input transaction carries one
// raw temperature and one raw pressure conversion; a zero conversion is treated as a
// read error and the last good value of that channel is reused. The six calibration
// words C1..C6 are written through the configuration port (index 0..5, others
// ignored). They are to be written only while the block is idle; the block itself
// does not enforce this. A single 26x26 signed multiplier is shared for all eight
// products (three temperature-coefficient terms, dT squared, two correction squares
// and the two halves of the pressure product), stepped by a 15-state sequencer. The
// input stall is high for the whole computation. A finished result waits in an output
// register, so the next transaction can be accepted while it is still pending; a
// second result that finds the register still stalled holds the sequencer in its
// last step. Pressure is saturated to the signed 32-bit range.
module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CAL_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [RAW_W-1:0]         i_raw_temperature,
    input  logic [RAW_W-1:0]         i_raw_pressure,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [TEMP_W-1:0] o_temperature_centideg,
    output logic signed [PRES_W-1:0] o_pressure_pa
);

    t_cal r_cal;

    // Calibration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_C1:  r_cal.c1 <= i_cfg_data;
                REG_C2:  r_cal.c2 <= i_cfg_data;
                REG_C3:  r_cal.c3 <= i_cfg_data;
                REG_C4:  r_cal.c4 <= i_cfg_data;
                REG_C5:  r_cal.c5 <= i_cfg_data;
                REG_C6:  r_cal.c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bptc_core u_core (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cal                  (r_cal),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_raw_temperature      (i_raw_temperature),
        .i_raw_pressure         (i_raw_pressure),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_temperature_centideg (o_temperature_centideg),
        .o_pressure_pa          (o_pressure_pa)
    );

endmodule

>>> design/bptc_mul.sv
// Shared signed multiplier with a registered product.
module bptc_mul
    import bptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // One product per cycle, available the cycle after issue
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

>>> design/bptc_core.sv
// Sequencer and datapath: steps the shared multiplier through the compensation.
module bptc_core
    import bptc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cal                     i_cal,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [RAW_W-1:0]         i_raw_temperature,
    input  logic [RAW_W-1:0]         i_raw_pressure,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [TEMP_W-1:0] o_temperature_centideg,
    output logic signed [PRES_W-1:0] o_pressure_pa
);

    t_state r_state, n_state;

    logic [RAW_W-1:0]         r_kept_t;
    logic [RAW_W-1:0]         r_kept_p;
    logic signed [DT_W-1:0]   r_dt;
    logic signed [TEMP_W-1:0] r_temp;
    logic [TEMP_W-1:0]        r_t2;
    logic signed [ACC_W-1:0]  r_off;
    logic signed [ACC_W-1:0]  r_sens;
    logic [ACC_W-1:0]         r_d;
    logic [ACC_W-1:0]         r_c5d;
    logic [ACC_W-1:0]         r_c7e;
    logic [ACC_W-1:0]         r_c22e;
    logic signed [PSUM_W-1:0] r_pacc;

    logic                     r_out_valid;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic signed [PRES_W-1:0] r_out_pres;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                     accept;
    logic                     out_load;
    logic                     low;
    logic                     vlow;
    logic signed [TEMP_W-1:0] tdiff_ref;
    logic signed [TEMP_W-1:0] tdiff_vlow;
    logic [ACC_W-1:0]         e_val;
    logic [ACC_W-1:0]         off2;
    logic [ACC_W-1:0]         sens2;
    logic signed [PSUM_W-1:0] hi_ext;
    logic signed [PSUM_W-1:0] off_ext;
    logic signed [PSUM_W-1:0] p_shift;
    logic signed [PRES_W-1:0] p_sat;

    bptc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Second-order correction regions
    assign low        = (r_temp < TEMP_REF);
    assign vlow       = (r_temp < TEMP_VLOW);
    assign tdiff_ref  = r_temp - TEMP_REF;
    assign tdiff_vlow = r_temp - TEMP_VLOW;

    // Correction terms, floored on the whole sum
    assign e_val  = prod[ACC_W-1:0];
    assign off2   = (r_c5d >> 1) + r_c7e;
    assign sens2  = (r_c5d + r_c22e) >> 2;

    assign hi_ext  = PSUM_W'(prod);
    assign off_ext = PSUM_W'(r_off);

    // Final scaling and saturation
    assign p_shift = r_pacc >>> 15;
    always_comb begin
        if (p_shift > PRES_MAX) begin
            p_sat = PRES_MAX[PRES_W-1:0];
        end else if (p_shift < PRES_MIN) begin
            p_sat = PRES_MIN[PRES_W-1:0];
        end else begin
            p_sat = p_shift[PRES_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_DT;
            S_DT:    n_state = S_MTEMP;
            S_MTEMP: n_state = S_MOFF;
            S_MOFF:  n_state = S_MSENS;
            S_MSENS: n_state = S_MT2;
            S_MT2:   n_state = S_MD;
            S_MD:    n_state = S_ME;
            S_ME:    n_state = S_CORR1;
            S_CORR1: n_state = S_CORR2;
            S_CORR2: n_state = S_MPL;
            S_MPL:   n_state = S_MPH;
            S_MPH:   n_state = S_PSUM;
            S_PSUM:  n_state = S_PSUB;
            S_PSUB:  n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Multiplier operand select and result load
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        out_load = 1'b0;
        unique case (r_state)
            S_MTEMP: begin
                mul_a = $signed(MUL_W'(i_cal.c6));
                mul_b = MUL_W'(r_dt);
            end
            S_MOFF: begin
                mul_a = $signed(MUL_W'(i_cal.c4));
                mul_b = MUL_W'(r_dt);
            end
            S_MSENS: begin
                mul_a = $signed(MUL_W'(i_cal.c3));
                mul_b = MUL_W'(r_dt);
            end
            S_MT2: begin
                mul_a = MUL_W'(r_dt);
                mul_b = MUL_W'(r_dt);
            end
            S_MD: begin
                mul_a = MUL_W'(tdiff_ref);
                mul_b = MUL_W'(tdiff_ref);
            end
            S_ME: begin
                mul_a = MUL_W'(tdiff_vlow);
                mul_b = MUL_W'(tdiff_vlow);
            end
            S_MPL: begin
                mul_a = $signed(MUL_W'(r_kept_p));
                mul_b = $signed(MUL_W'(r_sens[19:0]));
            end
            S_MPH: begin
                // upper half carries the sign of SENS
                mul_a = $signed(MUL_W'(r_kept_p));
                mul_b = MUL_W'($signed(r_sens[ACC_W-1:20]));
            end
            S_DONE: out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Kept raw conversions: a zero reading keeps the last good one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_t <= '0;
            r_kept_p <= '0;
        end else if (accept) begin
            if (i_raw_temperature != '0) r_kept_t <= i_raw_temperature;
            if (i_raw_pressure != '0)    r_kept_p <= i_raw_pressure;
        end
    end

    // Datapath registers, one step per state
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_DT: r_dt <= $signed({1'b0, r_kept_t}) - $signed({1'b0, i_cal.c5, 8'b0});
            S_MOFF: r_temp <= $signed(prod[41:23]) + TEMP_REF;
            S_MSENS: r_off <= $signed({8'b0, i_cal.c2, 16'b0}) + $signed(prod[46:7]);
            S_MT2: r_sens <= $signed({9'b0, i_cal.c1, 15'b0}) + $signed(prod[47:8]);
            S_MD: r_t2 <= low ? prod[49:31] : '0;
            S_ME: r_d <= low ? prod[ACC_W-1:0] : '0;
            S_CORR1: begin
                r_c5d  <= {r_d[ACC_W-3:0], 2'b0} + r_d;
                r_c7e  <= vlow ? ({e_val[ACC_W-4:0], 3'b0} - e_val) : '0;
                r_c22e <= vlow ? ({e_val[ACC_W-5:0], 4'b0} + {e_val[ACC_W-3:0], 2'b0}
                                  + {e_val[ACC_W-2:0], 1'b0}) : '0;
            end
            S_CORR2: begin
                r_temp <= r_temp - $signed(r_t2);
                r_off  <= r_off - $signed(off2);
                r_sens <= r_sens - $signed(sens2);
            end
            S_MPH:  r_pacc <= $signed({{(PSUM_W-PROD_W){1'b0}}, prod});
            S_PSUM: r_pacc <= r_pacc + (hi_ext <<< 20);
            S_PSUB: r_pacc <= (r_pacc >>> 21) - off_ext;
            default: ;
        endcase
    end

    // Output register: holds a finished transaction until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_temp <= r_temp;
            r_out_pres <= p_sat;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_temperature_centideg = r_out_temp;
    assign o_pressure_pa          = r_out_pres;

`ifndef ASSERT_OFF
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result valid without a finished computation");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_DT)
        else $error("accepted transaction did not start the sequence");

    a_keep_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_raw_temperature != '0) |=> r_kept_t == $past(i_raw_temperature))
        else $error("valid temperature conversion not kept");

    a_no_corr_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORR2 && !low) |-> (r_c5d == '0 && r_c7e == '0 && r_c22e == '0))
        else $error("second-order correction applied at or above 20 degC");
`endif

endmodule

>>> dv/baro_pressure_temp_compensation_test.sv
// Self-checking testbench for the barometer temperature and pressure compensation block.
module baro_pressure_temp_compensation_test;
    import bptc_pkg::*;

    // Indexes that map to no calibration word; writes to them must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 8;
    localparam int STALL_LIMIT     = 2000;  // cycles without any transaction
    localparam int TAIL_CYCLES     = 40;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [IDX_W-1:0]         i_cfg_index = '0;
    logic [CAL_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [RAW_W-1:0]         i_raw_temperature = '0;
    logic [RAW_W-1:0]         i_raw_pressure = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [TEMP_W-1:0] o_temperature_centideg;
    logic signed [PRES_W-1:0] o_pressure_pa;

    baro_pressure_temp_compensation uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_raw_temperature      (i_raw_temperature),
        .i_raw_pressure         (i_raw_pressure),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_temperature_centideg (o_temperature_centideg),
        .o_pressure_pa          (o_pressure_pa)
    );

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic signed [PRES_W-1:0] pres;
    } t_comp_reading;

    // Compensation predictor plus the queue of readings still owed by the block
    class baro_comp_scoreboard;
        t_cal             cal;
        bit [RAW_W-1:0]   held_temp;
        bit [RAW_W-1:0]   held_pres;
        t_comp_reading    owed_q[$];
        int               errors;

        function new();
            cal       = '0;
            held_temp = '0;
            held_pres = '0;
            errors    = 0;
        endfunction

        function void write_cal(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] val);
            case (idx)
                REG_C1: cal.c1 = val;
                REG_C2: cal.c2 = val;
                REG_C3: cal.c3 = val;
                REG_C4: cal.c4 = val;
                REG_C5: cal.c5 = val;
                REG_C6: cal.c6 = val;
                default: ;
            endcase
        endfunction

        function t_comp_reading compensate();
            longint c1, c2, c3, c4, c5, c6, tref, tvlow;
            longint dt, temp, off, sens, t2, off2, sens2, d, e, p;
            t_comp_reading r;
            c1 = longint'(cal.c1);
            c2 = longint'(cal.c2);
            c3 = longint'(cal.c3);
            c4 = longint'(cal.c4);
            c5 = longint'(cal.c5);
            c6 = longint'(cal.c6);
            tref  = longint'(TEMP_REF);
            tvlow = longint'(TEMP_VLOW);
            // first order; >>> on signed values is a floor division
            dt   = longint'(held_temp) - (c5 << 8);
            temp = tref + ((c6 * dt) >>> 23);
            off  = (c2 << 16) + ((c4 * dt) >>> 7);
            sens = (c1 << 15) + ((c3 * dt) >>> 8);
            t2    = 0;
            off2  = 0;
            sens2 = 0;
            // second order below 20 degC, extra terms below -15 degC
            if (temp < tref) begin
                d     = (temp - tref) * (temp - tref);
                t2    = (dt * dt) >>> 31;
                off2  = (5 * d) >>> 1;
                sens2 = (5 * d) >>> 2;
                if (temp < tvlow) begin
                    e     = (temp - tvlow) * (temp - tvlow);
                    off2  = ((5 * d) >>> 1) + 7 * e;
                    sens2 = (5 * d + 22 * e) >>> 2;
                end
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
            p = (((longint'(held_pres) * sens) >>> 21) - off) >>> 15;
            if (p > PRES_MAX) p = PRES_MAX;
            if (p < PRES_MIN) p = PRES_MIN;
            r.temp = temp[TEMP_W-1:0];
            r.pres = p[PRES_W-1:0];
            return r;
        endfunction

        // Accepted conversion pair: zero is a read error, keep the last good value
        function void note_conversion(bit [RAW_W-1:0] t, bit [RAW_W-1:0] p);
            if (t != 0) held_temp = t;
            if (p != 0) held_pres = p;
            owed_q.push_back(compensate());
        endfunction

        function void check_result(logic signed [TEMP_W-1:0] temp,
                                   logic signed [PRES_W-1:0] pres);
            t_comp_reading want;
            if (owed_q.size() == 0) begin
                $display("%0t unexpected result: temperature %0d pressure %0d",
                         $time, temp, pres);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (temp !== want.temp) begin
                $display("%0t temperature mismatch: expected %0d actual %0d",
                         $time, want.temp, temp);
                errors++;
            end
            if (pres !== want.pres) begin
                $display("%0t pressure mismatch: expected %0d actual %0d",
                         $time, want.pres, pres);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    baro_comp_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: note accepted inputs, check accepted results, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_conversion(i_raw_temperature, i_raw_pressure);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_temperature_centideg, o_pressure_pa);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic int sender_gap();
        int g;
        g = 0;
        if (send_idle_pct == 0) return 0;
        // occasional long gap so idle time lands on every sequencer step
        if ($urandom_range(99) < send_idle_pct / 4) return $urandom_range(24);
        while (g < 64 && $urandom_range(99) < send_idle_pct) g++;
        return g;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [RAW_W-1:0] t, input logic [RAW_W-1:0] p);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_raw_temperature <= t;
        i_raw_pressure    <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every owed reading has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_beat(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_cal(idx, val);
        @(negedge i_clk);
    endtask

    // Full calibration load, bracketed by writes to the unmapped indexes
    task automatic load_calibration(input t_cal cal);
        cfg_beat(REG_SPARE_6, CAL_W'($urandom));
        cfg_beat(REG_C1, cal.c1);
        cfg_beat(REG_C2, cal.c2);
        cfg_beat(REG_C3, cal.c3);
        cfg_beat(REG_C4, cal.c4);
        cfg_beat(REG_C5, cal.c5);
        cfg_beat(REG_C6, cal.c6);
        cfg_beat(REG_SPARE_7, CAL_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CAL_W-1:0] random_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return CAL_W'($urandom);
        endcase
    endfunction

    function automatic t_cal random_cal();
        t_cal c;
        c.c1 = random_word();
        c.c2 = random_word();
        c.c3 = random_word();
        c.c4 = random_word();
        c.c5 = random_word();
        c.c6 = random_word();
        return c;
    endfunction

    // Raw temperature: errors, extremes, full range, and in half the draws near the reference
    function automatic logic [RAW_W-1:0] random_raw_temp();
        int base, span, v;
        case ($urandom_range(9))
            0: return '0;
            1: return $urandom_range(1) ? {RAW_W{1'b1}} : RAW_W'(1);
            2, 3, 4: return RAW_W'($urandom);
            default: begin
                base = int'(sb.cal.c5) << 8;
                span = 1 << $urandom_range(22, 4);
                v = base + int'($urandom_range(2 * span)) - span;
                if (v < 1) v = 1;
                if (v > 24'hFFFFFF) v = 24'hFFFFFF;
                return v[RAW_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] random_raw_pres();
        case ($urandom_range(19))
            0, 1: return '0;
            2:    return $urandom_range(1) ? {RAW_W{1'b1}} : RAW_W'(1);
            default: return RAW_W'($urandom);
        endcase
    endfunction

    initial begin
        t_cal typical, edge_cal, cal;
        sb = new();
        typical = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                    c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
        // C6 = 2^13 and C5*256 = 2^23 put TEMP thresholds on exact raw values
        edge_cal = typical;
        edge_cal.c5 = 16'h8000;
        edge_cal.c6 = 16'd8192;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset calibration, nothing valid received yet
        send_item(24'd0, 24'd0);
        send_item(24'hFFFFFF, 24'hFFFFFF);
        drain();

        // Directed: typical calibration, read errors keep previous values
        load_calibration(typical);
        send_item(24'd8077636, 24'd9085466);
        send_item(24'd0, 24'd0);
        send_item(24'd0, 24'd1);
        send_item(24'd1, 24'd0);
        send_item(24'd1, 24'd1);
        send_item(24'hFFFFFF, 24'd1);
        send_item(24'd1, 24'hFFFFFF);
        send_item(24'd7877636, 24'd9085466);
        send_item(24'd5000000, 24'd0);
        drain();

        // Directed: threshold boundaries at 20.00 and -15.00 degC
        load_calibration(edge_cal);
        send_item(24'd8388608, 24'd9085466);
        send_item(24'd8388607, 24'd0);
        send_item(24'd4804608, 24'd0);
        send_item(24'd4804607, 24'd0);
        send_item(24'd1, 24'hFFFFFF);
        send_item(24'hFFFFFF, 24'hFFFFFF);
        drain();

        // Directed: every word at its maximum, deepest cold and hottest corners
        load_calibration('1);
        send_item(24'd1, 24'hFFFFFF);
        send_item(24'hFFFFFF, 24'hFFFFFF);
        send_item(24'd1, 24'd1);
        send_item(24'h800000, 24'h800000);
        drain();

        // Random phases over calibration sets and idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       cal = typical;
                1:       cal = '0;
                2:       cal = '1;
                default: cal = random_cal();
            endcase
            drain();
            load_calibration(cal);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_raw_temp(), random_raw_pres());
                if ($urandom_range(99) == 0) drain();
            end
        end

        // Wind down
        drain();
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0t %0d expected readings never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
design/bptc_pkg.sv
design/bptc_mul.sv
design/bptc_core.sv
design/baro_pressure_temp_compensation.sv
dv/baro_pressure_temp_compensation_test.sv
